// ----- rtl/plst_pkg.sv -----
// shared types and constants for the positional list store
package plst_pkg;

  // storage geometry and port field widths
  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned POS_W      = 5;
  localparam int unsigned STAT_W     = 2;

  // operation codes
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_READ   = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;  // capture the incoming operation
    logic exec;  // carry out the captured operation
  } ctrl_t;

endpackage

// ----- rtl/plst_ctrl.sv -----
// controller state machine for the positional list store
module plst_ctrl
  import plst_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output logic  busy_o,
  output logic  done_o,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic   done_q, done_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o = '0;
    busy_o = 1'b0;
    done_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        ctrl_o.load = start_i;
      end
      S_EXEC: begin
        ctrl_o.exec = 1'b1;
        busy_o      = 1'b1;
        done_d      = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

  // state and result strobe registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign done_o = done_q;

endmodule

// ----- rtl/plst_dpath.sv -----
// datapath of the positional list store: entry cells, count and result registers
module plst_dpath
  import plst_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_t                 ctrl_i,
  input  logic [1:0]            operation_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [POS_W-1:0]      position_i,
  output logic [DATA_WIDTH-1:0] read_value_o,
  output logic [STAT_W-1:0]     status_o,
  output logic [CNT_W-1:0]      count_o,
  output logic                  is_empty_o
);

  // captured operation
  op_e                   op_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [POS_W-1:0]      pos_q;

  // entry cells, slot 0 is the head
  logic [DATA_WIDTH-1:0] cells_q [DEPTH];
  logic [DATA_WIDTH-1:0] cells_d [DEPTH];
  logic [CNT_W-1:0]      count_q, count_d;

  // result registers
  logic [DATA_WIDTH-1:0] rv_q, rv_d;
  status_e               st_q, st_d;

  logic             full;
  logic             pos_bad;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] tail_idx;
  logic             do_app, do_ins, do_rem;

  assign full     = (count_q == CNT_W'(DEPTH));
  assign pos_bad  = (pos_q == '0) || (CNT_W'(pos_q) > count_q);
  assign pos_idx  = IDX_W'(pos_q - POS_W'(1));
  assign tail_idx = count_q[IDX_W-1:0];

  // decode the operation into status, read data and cell actions
  always_comb begin
    rv_d    = '0;
    st_d    = ST_OK;
    do_app  = 1'b0;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    count_d = count_q;
    case (op_q)
      OP_APPEND, OP_INSERT: begin
        if (full) begin
          st_d = ST_FULL;
        end else begin
          do_app  = (op_q == OP_APPEND);
          do_ins  = (op_q == OP_INSERT);
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_READ: begin
        if (pos_bad) begin
          st_d = ST_BAD_POS;
        end else begin
          rv_d = cells_q[pos_idx];
        end
      end
      OP_REMOVE: begin
        if (pos_bad) begin
          st_d = ST_BAD_POS;
        end else begin
          do_rem  = 1'b1;
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
        st_d = ST_OK;
      end
    endcase
  end

  // per-cell next value: each cell looks only at its neighbors and the captured value
  always_comb begin
    for (int unsigned i = 0; i < DEPTH; i++) begin
      cells_d[i] = cells_q[i];
      if (do_app && (tail_idx == IDX_W'(i))) begin
        cells_d[i] = val_q;
      end
      if (do_ins) begin
        cells_d[i] = (i == 0) ? val_q : cells_q[(i == 0) ? 0 : i - 1];
      end
      if (do_rem && (IDX_W'(i) >= pos_idx) && (i < DEPTH - 1)) begin
        cells_d[i] = cells_q[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // operation capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q  <= op_e'(operation_i);
      val_q <= value_i;
      pos_q <= position_i;
    end
  end

  // entry cells and result data
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      cells_q <= cells_d;
      rv_q    <= rv_d;
      st_q    <= st_d;
    end
  end

  // entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.exec) begin
      count_q <= count_d;
    end
  end

  assign read_value_o = rv_q;
  assign status_o     = st_q;
  assign count_o      = count_q;
  assign is_empty_o   = (count_q == '0);

endmodule

// ----- rtl/positional_list_store_top.sv -----
// top level of the positional list store
//
// An ordered list of up to 16 data words. Each command is one operation:
// append at the tail, insert at the head, read the entry at a 1-based
// position, or remove the entry at a 1-based position and close the gap.
// A command transfer happens at a rising edge with start_i high and busy_o
// low. Operation, value and position are sampled at that edge.
// The command runs in the following cycle (busy_o high), in which the entry
// cells update in parallel, shifting for insert and remove. The result then
// shows on the result ports, marked by done_o for exactly one cycle; that
// cycle ends the result transfer. The command is captured by the idle step
// and carried out by the execute step of the controller, so no new command
// is taken while busy_o is high, but one may come while the result shows.
// status_o: ok, bad position (read or remove outside 1..count), or full
// (append or insert with 16 entries, value dropped). count_o and is_empty_o
// give the state after the operation; read_value_o is zero except for a
// good read. The receiver cannot stall. Reset empties the list at once.
module positional_list_store_top
  import plst_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            operation_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [POS_W-1:0]      position_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] read_value_o,
  output logic [STAT_W-1:0]     status_o,
  output logic [CNT_W-1:0]      count_o,
  output logic                  is_empty_o
);

  ctrl_t ctrl;

  // sequencing
  plst_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .ctrl_o  (ctrl)
  );

  // storage and result
  plst_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .operation_i  (operation_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .count_o      (count_o),
    .is_empty_o   (is_empty_o)
  );

endmodule
